// ----- rtl/rtcu_pkg.sv -----
// Shared constants, types and helper functions for the RTC date to Unix time converter.
package rtcu_pkg;

  localparam logic [7:0]  CENT_MIN           = 8'd19;
  localparam logic [7:0]  CENT_MAX           = 8'd21;
  localparam logic [4:0]  CENT_DEFAULT       = 5'd20;
  localparam logic [11:0] YEARS_PER_CENT     = 12'd100;
  localparam logic [11:0] EPOCH_YEAR         = 12'd1970;
  localparam logic [7:0]  MONTH_MAX          = 8'd12;
  localparam logic [7:0]  DAY_MAX            = 8'd31;
  localparam logic [9:0]  LEAPS_BEFORE_EPOCH = 10'd477;
  localparam logic [8:0]  DAYS_PER_YEAR      = 9'd365;
  localparam logic [16:0] SECS_PER_DAY       = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR      = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN       = 6'd60;
  // Reciprocal of 100: exact floor for all operands below 43699
  localparam logic [12:0] RECIP_100          = 13'd5243;
  localparam int unsigned RECIP_SHIFT        = 19;

  typedef struct packed {
    logic [7:0]  sec;
    logic [7:0]  min;
    logic [7:0]  hr;
    logic [7:0]  day;
    logic [7:0]  mon;
    logic [11:0] cal_year;
    logic        bad_md;
  } dec_t;

  // Unchecked BCD rule: low nibble plus ten times high nibble
  function automatic logic [7:0] nibble_decode(input logic [7:0] b);
    return 8'(b[3:0]) + 8'(b[7:4]) * 8'd10;
  endfunction

  // Days before the first of month m (1..12)
  function automatic logic [8:0] days_to_month(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/rtcu_in_if.sv -----
// Input channel carrying one raw RTC snapshot per transaction.
interface rtcu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_second;
  logic [7:0] raw_minute;
  logic [7:0] raw_hour;
  logic [7:0] raw_day;
  logic [7:0] raw_month;
  logic [7:0] raw_year;
  logic [7:0] raw_century;
  logic       binary_mode;

  modport source (
    output valid, raw_second, raw_minute, raw_hour, raw_day, raw_month,
           raw_year, raw_century, binary_mode,
    input  ready
  );
  modport sink (
    input  valid, raw_second, raw_minute, raw_hour, raw_day, raw_month,
           raw_year, raw_century, binary_mode,
    output ready
  );
endinterface

// ----- rtl/rtcu_out_if.sv -----
// Result channel carrying Unix seconds and the invalid-date flag.
interface rtcu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] unix_seconds;
  logic        date_invalid;

  modport source (output valid, unix_seconds, date_invalid, input ready);
  modport sink   (input valid, unix_seconds, date_invalid, output ready);
endinterface

// ----- rtl/rtcu_decode.sv -----
// Front end: BCD or binary field decode, century fix-up, full year and month/day range check.
module rtcu_decode (
  input  logic [7:0]       raw_second,
  input  logic [7:0]       raw_minute,
  input  logic [7:0]       raw_hour,
  input  logic [7:0]       raw_day,
  input  logic [7:0]       raw_month,
  input  logic [7:0]       raw_year,
  input  logic [7:0]       raw_century,
  input  logic             binary_mode,
  output rtcu_pkg::dec_t   dec
);

  logic [7:0] yr;
  logic [7:0] cen;
  logic [4:0] cen_fix;

  always_comb begin
    if (binary_mode) begin
      dec.sec = raw_second;
      dec.min = raw_minute;
      dec.hr  = raw_hour;
      dec.day = raw_day;
      dec.mon = raw_month;
      yr      = raw_year;
      cen     = raw_century;
    end else begin
      dec.sec = rtcu_pkg::nibble_decode(raw_second);
      dec.min = rtcu_pkg::nibble_decode(raw_minute);
      dec.hr  = rtcu_pkg::nibble_decode(raw_hour);
      dec.day = rtcu_pkg::nibble_decode(raw_day);
      dec.mon = rtcu_pkg::nibble_decode(raw_month);
      yr      = rtcu_pkg::nibble_decode(raw_year);
      cen     = rtcu_pkg::nibble_decode(raw_century);
    end

    // Force an unknown century to 20
    if (cen < rtcu_pkg::CENT_MIN || cen > rtcu_pkg::CENT_MAX) begin
      cen_fix = rtcu_pkg::CENT_DEFAULT;
    end else begin
      cen_fix = cen[4:0];
    end

    dec.cal_year  = 12'(cen_fix) * rtcu_pkg::YEARS_PER_CENT + 12'(yr);
    dec.bad_md    = (dec.mon == 8'd0) || (dec.mon > rtcu_pkg::MONTH_MAX) ||
                    (dec.day == 8'd0) || (dec.day > rtcu_pkg::DAY_MAX);
  end

endmodule

// ----- rtl/rtc_date_to_unix_time.sv -----
// Top level: five-stage pipeline from raw RTC snapshot to Unix seconds.
// Throughput: one transaction per cycle while the result side is ready; each
// stage holds one item and the ready chain lets a stage fill whenever the one
// after it moves or is empty.
// Stage 5 is the output register and its product of days by 86400 sets depth.
// Reset (rst_n low, synchronous) clears every stage valid bit; payload is kept.
module rtc_date_to_unix_time (
  input  logic        clk,
  input  logic        rst_n,
  rtcu_in_if.sink     in_chan,
  rtcu_out_if.source  out_chan
);

  localparam int unsigned NSTG = 5;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] rdy;

  rtcu_pkg::dec_t dec;

  // Stage 1
  rtcu_pkg::dec_t s1_r;
  // Stage 2
  logic [11:0] s2_full_r;
  logic [5:0]  s2_qm1_r;
  logic [5:0]  s2_qf_r;
  logic [19:0] s2_hms_r;
  logic [7:0]  s2_day_r;
  logic [7:0]  s2_mon_r;
  logic        s2_inv_r;
  // Stage 3
  logic [17:0] s3_yd_r;
  logic [9:0]  s3_leaps_r;
  logic [8:0]  s3_dtm_r;
  logic        s3_ladd_r;
  logic [7:0]  s3_day_r;
  logic [19:0] s3_hms_r;
  logic        s3_inv_r;
  // Stage 4
  logic [17:0] s4_days_r;
  logic [19:0] s4_hms_r;
  logic        s4_inv_r;
  // Stage 5 (output)
  logic [31:0] out_sec_r;
  logic        out_inv_r;

  logic [11:0] s1_ym1;
  logic [24:0] s1_pm1;
  logic [24:0] s1_pf;
  logic [19:0] s1_hms;
  logic [11:0] s2_ym1;
  logic [8:0]  s2_yoff;
  logic [11:0] s2_cent_base;
  logic        s2_leap_yr;
  logic [34:0] s4_prod;
  logic [31:0] s4_total;

  rtcu_decode u_decode (
    .raw_second  (in_chan.raw_second),
    .raw_minute  (in_chan.raw_minute),
    .raw_hour    (in_chan.raw_hour),
    .raw_day     (in_chan.raw_day),
    .raw_month   (in_chan.raw_month),
    .raw_year    (in_chan.raw_year),
    .raw_century (in_chan.raw_century),
    .binary_mode (in_chan.binary_mode),
    .dec         (dec)
  );

  // A stage takes new data when it is empty or its content moves on
  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || out_chan.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_chan.ready         = rdy[0];
  assign out_chan.valid        = v_r[NSTG-1];
  assign out_chan.unix_seconds = out_sec_r;
  assign out_chan.date_invalid = out_inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_chan.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 2 arithmetic: quotients by 100 and time of day
  always_comb begin
    s1_ym1 = s1_r.cal_year - 12'd1;
    s1_pm1 = 25'(s1_ym1) * 25'(rtcu_pkg::RECIP_100);
    s1_pf  = 25'(s1_r.cal_year) * 25'(rtcu_pkg::RECIP_100);
    s1_hms = 20'(s1_r.hr) * 20'(rtcu_pkg::SECS_PER_HOUR)
           + 20'(s1_r.min) * 20'(rtcu_pkg::SECS_PER_MIN)
           + 20'(s1_r.sec);
  end

  // Stage 3 arithmetic: leap count, leap year, whole-year days
  always_comb begin
    s2_ym1       = s2_full_r - 12'd1;
    s2_yoff      = 9'(s2_full_r - rtcu_pkg::EPOCH_YEAR);
    s2_cent_base = 12'(s2_qf_r) * rtcu_pkg::YEARS_PER_CENT;
    s2_leap_yr   = (s2_full_r[1:0] == 2'd0) &&
                   ((s2_full_r != s2_cent_base) || (s2_qf_r[1:0] == 2'd0));
  end

  // Stage 5 arithmetic: days to seconds, wrapped to 32 bits
  always_comb begin
    s4_prod  = 35'(s4_days_r) * 35'(rtcu_pkg::SECS_PER_DAY);
    s4_total = s4_prod[31:0] + 32'(s4_hms_r);
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_r <= dec;
    end
    if (rdy[1]) begin
      s2_full_r <= s1_r.cal_year;
      s2_qm1_r  <= 6'(s1_pm1 >> rtcu_pkg::RECIP_SHIFT);
      s2_qf_r   <= 6'(s1_pf >> rtcu_pkg::RECIP_SHIFT);
      s2_hms_r  <= s1_hms;
      s2_day_r  <= s1_r.day;
      s2_mon_r  <= s1_r.mon;
      s2_inv_r  <= s1_r.bad_md || (s1_r.cal_year < rtcu_pkg::EPOCH_YEAR);
    end
    if (rdy[2]) begin
      s3_yd_r    <= 18'(s2_yoff) * 18'(rtcu_pkg::DAYS_PER_YEAR);
      s3_leaps_r <= 10'(s2_ym1[11:2]) - 10'(s2_qm1_r) + 10'(s2_qm1_r[5:2])
                  - rtcu_pkg::LEAPS_BEFORE_EPOCH;
      s3_dtm_r   <= rtcu_pkg::days_to_month(s2_mon_r[3:0]);
      s3_ladd_r  <= s2_leap_yr && (s2_mon_r > 8'd2);
      s3_day_r   <= s2_day_r;
      s3_hms_r   <= s2_hms_r;
      s3_inv_r   <= s2_inv_r;
    end
    if (rdy[3]) begin
      s4_days_r <= s3_yd_r + 18'(s3_leaps_r) + 18'(s3_dtm_r) + 18'(s3_ladd_r)
                 + 18'(s3_day_r) - 18'd1;
      s4_hms_r  <= s3_hms_r;
      s4_inv_r  <= s3_inv_r;
    end
    if (rdy[4]) begin
      // Drop the computed value for a rejected date
      out_sec_r <= s4_inv_r ? 32'd0 : s4_total;
      out_inv_r <= s4_inv_r;
    end
  end

  // Rejected date always reports zero seconds
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.date_invalid |-> out_chan.unix_seconds == 32'd0)
    else $error("invalid date with nonzero seconds");

  // Occupancy changes only by accepted transactions
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      $countones(v_r) == $past($countones(v_r))
                       + $past(int'(in_chan.valid && in_chan.ready))
                       - $past(int'(out_chan.valid && out_chan.ready)))
    else $error("pipeline occupancy mismatch");

  // Reciprocal quotient by 100 is exact for every accepted year
  a_quot100: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] && !s2_inv_r |->
      (13'(s2_qf_r) * 13'd100 <= 13'(s2_full_r)) &&
      (13'(s2_full_r) < 13'(s2_qf_r) * 13'd100 + 13'd100))
    else $error("quotient by 100 out of range");

endmodule

// ----- tb/sv/unix_time_checker.sv -----
// Checker for the RTC date to Unix time converter: predicts each snapshot's result and compares.
`timescale 1ns / 100ps

module unix_time_checker (
  input  logic        clk,
  input  logic        rst_n,
  rtcu_in_if          in_mon,
  rtcu_out_if         out_mon,
  output int unsigned mismatch_count,
  output int unsigned pending_count
);

  typedef struct packed {
    logic [31:0] seconds;
    logic        invalid;
  } unix_result_t;

  int unsigned  month_start [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
  unix_result_t expected_q [$];
  unix_result_t want;
  int unsigned  errs;

  function automatic int unsigned bcd_value(input logic [7:0] b);
    return int'(b[3:0]) + int'(b[7:4]) * 10;
  endfunction

  function automatic int unsigned leap_years_upto(input int unsigned n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic bit is_leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic unix_result_t predict_unix_time(
    input logic [7:0] sec_b, min_b, hr_b, day_b, mon_b, yr_b, cen_b,
    input logic       bin
  );
    int unsigned  secs, mins, hrs, mday, mon, yr, cent, full, days;
    unix_result_t r;
    secs = 32'(sec_b);
    mins = 32'(min_b);
    hrs  = 32'(hr_b);
    mday = 32'(day_b);
    mon  = 32'(mon_b);
    yr   = 32'(yr_b);
    cent = 32'(cen_b);
    if (!bin) begin
      secs = bcd_value(sec_b);
      mins = bcd_value(min_b);
      hrs  = bcd_value(hr_b);
      mday = bcd_value(day_b);
      mon  = bcd_value(mon_b);
      yr   = bcd_value(yr_b);
      cent = bcd_value(cen_b);
    end
    if (cent < 19 || cent > 21) cent = 20;
    full = cent * 100 + yr;
    if (full < 1970 || mon < 1 || mon > 12 || mday < 1 || mday > 31) begin
      r.seconds = '0;
      r.invalid = 1'b1;
      return r;
    end
    days = 365 * (full - 1970) + leap_years_upto(full - 1) - leap_years_upto(1969)
         + month_start[mon - 1] + ((mon > 2 && is_leap_year(full)) ? 1 : 0) + mday - 1;
    r.seconds = days * 86400 + hrs * 3600 + mins * 60 + secs;
    r.invalid = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_q.delete();
      pending_count  <= 0;
      mismatch_count <= 0;
    end else begin
      errs = 0;
      // retire the oldest prediction before queuing a new one
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction: unix_seconds=%0d date_invalid=%0b",
                 out_mon.unix_seconds, out_mon.date_invalid);
          errs++;
        end else begin
          want = expected_q.pop_front();
          if (out_mon.unix_seconds !== want.seconds) begin
            $error("unix_seconds: expected %0d, actual %0d", want.seconds,
                   out_mon.unix_seconds);
            errs++;
          end
          if (out_mon.date_invalid !== want.invalid) begin
            $error("date_invalid: expected %0b, actual %0b", want.invalid,
                   out_mon.date_invalid);
            errs++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(predict_unix_time(in_mon.raw_second, in_mon.raw_minute,
                                               in_mon.raw_hour, in_mon.raw_day,
                                               in_mon.raw_month, in_mon.raw_year,
                                               in_mon.raw_century, in_mon.binary_mode));
      pending_count  <= expected_q.size();
      mismatch_count <= mismatch_count + (errs != 0 ? 1 : 0);
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top: drives RTC snapshots and result back-pressure, gives the verdict.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned SETTLE_TICKS = 20;

  typedef struct packed {
    logic       binary;
    logic [7:0] century;
    logic [7:0] year;
    logic [7:0] month;
    logic [7:0] day;
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] second;
  } rtc_snapshot_t;

  logic          clk;
  logic          rst_n;
  int unsigned   mismatch_count;
  int unsigned   pending_count;
  bit            src_steady;
  bit            sink_steady;
  bit            long_hold_req;
  bit            sink_holding;
  rtc_snapshot_t directed_q [$];

  rtcu_in_if  in_chan ();
  rtcu_out_if out_chan ();

  rtc_date_to_unix_time u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  unix_time_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] to_bcd(input int unsigned v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  function automatic rtc_snapshot_t make_snap(
    input logic bin, input logic [7:0] cen, yr, mon, dy, hr, mn, sc
  );
    rtc_snapshot_t s;
    s.binary  = bin;
    s.century = cen;
    s.year    = yr;
    s.month   = mon;
    s.day     = dy;
    s.hour    = hr;
    s.minute  = mn;
    s.second  = sc;
    return s;
  endfunction

  function automatic rtc_snapshot_t random_snapshot();
    int unsigned   kind, cen, yr, mon, dy, hr, mn, sc;
    bit            bin;
    rtc_snapshot_t s;
    kind = $urandom_range(0, 99);
    bin  = 1'($urandom_range(0, 1));
    if (kind >= 90) begin
      // raw noise in every byte
      return make_snap(bin, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
    end
    cen = $urandom_range(19, 21);
    yr  = (cen == 19) ? $urandom_range(70, 99) : $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) cen = $urandom_range(0, 99);
    mon = $urandom_range(1, 12);
    dy  = $urandom_range(1, 31);
    hr  = $urandom_range(0, 23);
    mn  = $urandom_range(0, 59);
    sc  = $urandom_range(0, 59);
    if (bin) s = make_snap(1'b1, 8'(cen), 8'(yr), 8'(mon), 8'(dy), 8'(hr), 8'(mn),
                           8'(sc));
    else     s = make_snap(1'b0, to_bcd(cen), to_bcd(yr), to_bcd(mon), to_bcd(dy),
                           to_bcd(hr), to_bcd(mn), to_bcd(sc));
    if (kind >= 65 && kind < 80) begin
      // good date, time of day bytes unchecked
      s.hour   = 8'($urandom_range(0, 255));
      s.minute = 8'($urandom_range(0, 255));
      s.second = 8'($urandom_range(0, 255));
    end else if (kind >= 80) begin
      // break one date byte
      case ($urandom_range(0, 3))
        0: s.year  = 8'($urandom_range(0, 255));
        1: s.month = 8'($urandom_range(0, 255));
        2: s.day   = 8'($urandom_range(0, 255));
        default: s.century = 8'($urandom_range(0, 255));
      endcase
    end
    return s;
  endfunction

  task automatic send_snapshot(input rtc_snapshot_t s, input int unsigned gap);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.binary_mode <= s.binary;
    in_chan.raw_century <= s.century;
    in_chan.raw_year    <= s.year;
    in_chan.raw_month   <= s.month;
    in_chan.raw_day     <= s.day;
    in_chan.raw_hour    <= s.hour;
    in_chan.raw_minute  <= s.minute;
    in_chan.raw_second  <= s.second;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_snapshot(random_snapshot(), src_steady ? 0 : idle_gap());
  endtask

  // result side back-pressure
  initial begin
    int unsigned stall;
    out_chan.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        sink_holding  = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_holding = 1'b0;
      end else if (sink_steady) begin
        out_chan.ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        stall = idle_gap();
        if (stall != 0) begin
          out_chan.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // end the run when no transaction moves on either channel for too long
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.binary_mode <= 1'b0;
    in_chan.raw_century <= '0;
    in_chan.raw_year    <= '0;
    in_chan.raw_month   <= '0;
    in_chan.raw_day     <= '0;
    in_chan.raw_hour    <= '0;
    in_chan.raw_minute  <= '0;
    in_chan.raw_second  <= '0;

    // epoch in both modes, then the edges of the accepted range
    directed_q.push_back(make_snap(0, 'h19, 'h70, 'h01, 'h01, 'h00, 'h00, 'h00));
    directed_q.push_back(make_snap(1, 19, 70, 1, 1, 0, 0, 0));
    directed_q.push_back(make_snap(0, 'h19, 'h69, 'h12, 'h31, 'h23, 'h59, 'h59));
    directed_q.push_back(make_snap(0, 'h20, 'h24, 'h00, 'h15, 'h10, 'h20, 'h30));
    directed_q.push_back(make_snap(0, 'h20, 'h24, 'h13, 'h15, 'h10, 'h20, 'h30));
    directed_q.push_back(make_snap(1, 20, 24, 6, 0, 10, 20, 30));
    directed_q.push_back(make_snap(1, 20, 24, 6, 32, 10, 20, 30));
    directed_q.push_back(make_snap(0, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF));
    directed_q.push_back(make_snap(1, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF));
    directed_q.push_back(make_snap(0, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00));
    directed_q.push_back(make_snap(1, 'h80, 'h80, 'h80, 'h80, 'h80, 'h80, 'h80));
    // unchecked time of day on a good date
    directed_q.push_back(make_snap(0, 'h21, 'h99, 'h12, 'h31, 'hFF, 'hFF, 'hFF));
    directed_q.push_back(make_snap(1, 21, 255, 12, 31, 255, 255, 255));
    // leap handling
    directed_q.push_back(make_snap(0, 'h20, 'h00, 'h02, 'h29, 'h12, 'h00, 'h00));
    directed_q.push_back(make_snap(0, 'h20, 'h00, 'h03, 'h01, 'h00, 'h00, 'h00));
    directed_q.push_back(make_snap(1, 21, 0, 3, 1, 0, 0, 0));
    directed_q.push_back(make_snap(1, 24, 24, 12, 31, 23, 59, 59));
    // day past the end of the month runs on
    directed_q.push_back(make_snap(1, 20, 23, 2, 31, 8, 0, 0));
    // century outside 19..21 falls back to 20
    directed_q.push_back(make_snap(0, 'h18, 'h24, 'h07, 'h04, 'h12, 'h34, 'h56));
    directed_q.push_back(make_snap(1, 22, 24, 7, 4, 12, 34, 56));
    directed_q.push_back(make_snap(1, 0, 99, 12, 31, 23, 59, 59));
    // nibbles above nine pass through unchecked
    directed_q.push_back(make_snap(0, 'h19, 'hA5, 'h0C, 'h1F, 'h2A, 'h5F, 'h6E));
    // sign bit and 32-bit wrap
    directed_q.push_back(make_snap(1, 20, 38, 1, 19, 3, 14, 8));
    directed_q.push_back(make_snap(1, 21, 6, 2, 7, 6, 28, 16));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_q[i]) send_snapshot(directed_q[i], idle_gap());
    drain_results();

    // hold the result side while items keep coming so the pipeline backs up
    long_hold_req = 1'b1;
    while (!sink_holding) @(posedge clk);
    src_steady = 1'b1;
    send_random(40);
    drain_results();

    // back-to-back stretch with no stalls on either side
    sink_steady = 1'b1;
    send_random(200);
    src_steady  = 1'b0;
    sink_steady = 1'b0;

    send_random(1590);
    drain_results();
    repeat (SETTLE_TICKS) @(posedge clk);

    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
